FILE: src/btr_pkg.sv
package btr_pkg;

    // Number of keywords tracked in parallel and the width of a byte.
    localparam int KwCount = 8;
    localparam int ByteW   = 8;

    // Keyword slots in the candidate mask.
    localparam int KW_TRUE  = 0;
    localparam int KW_FALSE = 1;
    localparam int KW_YES   = 2;
    localparam int KW_NO    = 3;
    localparam int KW_ON    = 4;
    localparam int KW_OFF   = 5;
    localparam int KW_ONE   = 6;
    localparam int KW_ZERO  = 7;

    // Keyword spelling, padded with zeros to eight characters so that a
    // three-bit length indexes every position.
    localparam logic [ByteW-1:0] KW_TEXT [KwCount][8] = '{
        '{8'h74, 8'h72, 8'h75, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h66, 8'h61, 8'h6C, 8'h73, 8'h65, 8'h00, 8'h00, 8'h00},
        '{8'h79, 8'h65, 8'h73, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h6E, 8'h6F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h6F, 8'h6E, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h6F, 8'h66, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h31, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h30, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    // Keyword lengths and the value that each keyword stands for.
    localparam logic [2:0] KW_LEN [KwCount] = '{
        3'd4, 3'd5, 3'd3, 3'd2, 3'd2, 3'd3, 3'd1, 3'd1
    };
    localparam logic [KwCount-1:0] KW_VAL = 8'b0101_0101;

    // Result of one text, handed from the scanner to the output register.
    typedef struct packed {
        logic done;
        logic bool_value;
        logic parse_ok;
    } t_result;

    // Space and the control characters from tab to carriage return.
    function automatic logic is_blank(input logic [ByteW-1:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    // Fold upper-case ASCII letters to lower case.
    function automatic logic [ByteW-1:0] fold(input logic [ByteW-1:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) ? (c | 8'h20) : c;
    endfunction

endpackage

FILE: src/btr_scan.sv
module btr_scan
    import btr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [ByteW-1:0] i_byte,
    output t_result          o_result
);

    typedef enum logic [1:0] {
        PH_LEAD  = 2'd0,
        PH_TOKEN = 2'd1,
        PH_TRAIL = 2'd2,
        PH_BAD   = 2'd3
    } t_phase;

    t_phase             r_phase, n_phase;
    logic [KwCount-1:0] r_mask, n_mask;
    logic [2:0]         r_len, n_len;

    logic [ByteW-1:0]   c;
    logic [KwCount-1:0] keep;
    logic               do_match;
    logic               found;
    logic               found_val;
    logic               is_end;

    assign c      = fold(i_byte);
    assign is_end = (i_byte == '0);

    // Keywords whose next character matches the current byte.
    always_comb begin
        for (int k = 0; k < KwCount; k++) begin
            keep[k] = r_mask[k] && (r_len < KW_LEN[k]) && (KW_TEXT[k][r_len] == c);
        end
    end

    // First keyword accepted at the end of the text, with its length rule.
    always_comb begin
        found     = 1'b0;
        found_val = 1'b0;
        for (int k = KwCount - 1; k >= 0; k--) begin
            logic len_ok;
            len_ok = r_mask[k] && (r_len != 3'd0) && (r_len <= KW_LEN[k]);
            if (k == KW_ON) begin
                len_ok = len_ok && (r_len == 3'd2);
            end else if (k == KW_OFF) begin
                len_ok = len_ok && (r_len >= 3'd2);
            end else if (k == KW_ONE || k == KW_ZERO) begin
                len_ok = len_ok && (r_len == 3'd1);
            end
            if (len_ok && (r_phase == PH_TOKEN || r_phase == PH_TRAIL)) begin
                found     = 1'b1;
                found_val = KW_VAL[k];
            end
        end
    end

    // Phase update for one byte; the end byte returns everything to reset.
    always_comb begin
        n_phase  = r_phase;
        do_match = 1'b0;
        if (!is_end) begin
            unique case (r_phase)
                PH_LEAD: begin
                    if (!is_blank(i_byte)) begin
                        n_phase  = PH_TOKEN;
                        do_match = 1'b1;
                    end
                end
                PH_TOKEN: begin
                    if (is_blank(i_byte)) begin
                        n_phase = PH_TRAIL;
                    end else begin
                        do_match = 1'b1;
                    end
                end
                PH_TRAIL: begin
                    if (!is_blank(i_byte)) begin
                        n_phase = PH_BAD;
                    end
                end
                PH_BAD: begin
                    n_phase = PH_BAD;
                end
                default: begin
                    n_phase = PH_BAD;
                end
            endcase
        end else begin
            n_phase = PH_LEAD;
        end
    end

    // Mask and saturating length follow the phase decision.
    always_comb begin
        n_mask = r_mask;
        n_len  = r_len;
        if (is_end) begin
            n_mask = '1;
            n_len  = '0;
        end else if (do_match) begin
            n_mask = keep;
            n_len  = (r_len != 3'd7) ? r_len + 3'd1 : r_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LEAD;
            r_mask  <= '1;
            r_len   <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_mask  <= n_mask;
            r_len   <= n_len;
        end
    end

    assign o_result.done       = i_step && is_end;
    assign o_result.bool_value = found && found_val;
    assign o_result.parse_ok   = found;

    // The end of a text leaves the scanner in its reset state.
    a_end_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && is_end) |=> (r_phase == PH_LEAD && r_len == 3'd0 && r_mask == '1))
        else $error("scanner not cleared after end of text");

    // Token length is zero exactly while leading whitespace is skipped.
    a_lead_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_LEAD) == (r_len == 3'd0))
        else $error("token length disagrees with scan phase");

    // A value of one is only reported for a recognized word.
    a_val_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.bool_value |-> o_result.parse_ok)
        else $error("value set without a recognized word");

endmodule

FILE: src/boolean_text_recognizer_unit.sv
// Boolean keyword recognizer.
//
// Input channel (i_text_valid, o_text_stall, i_text_byte): one character per
// request; a zero byte ends the text. Output channel (o_res_valid,
// i_res_stall, o_bool_value, o_parse_ok): one request per text, sent for
// the zero byte only. Whitespace around the token is skipped and the token
// is compared without regard to letter case against true, false, yes, no,
// on, off, 1 and 0 (prefixes allowed as described for each word).
//
// Throughput is one byte per cycle, except while an end byte waits for the
// output register. A byte is held in an input register and scanned from
// there; the result for a zero byte is loaded into the output register when
// it is scanned. The scanner state is one small register set updated by a
// single compare-and-mask step per byte.
//
// Synchronous active-low reset empties both registers and returns the
// scanner to the leading-whitespace state with all keywords live. While the
// receiver stalls, plain characters keep flowing; an end byte waits in the
// input register, and o_text_stall rises, until the output register frees.
module boolean_text_recognizer_unit
    import btr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_text_valid,
    output logic             o_text_stall,
    input  logic [ByteW-1:0] i_text_byte,
    output logic             o_res_valid,
    input  logic             i_res_stall,
    output logic             o_bool_value,
    output logic             o_parse_ok
);

    logic             r_in_vld;
    logic [ByteW-1:0] r_in_byte;
    logic             r_out_vld;
    logic             r_out_bool;
    logic             r_out_ok;

    logic             step;
    logic             in_take;
    logic             out_free;
    t_result          result;

    // The end byte needs a free output register; other bytes always move.
    assign out_free     = !r_out_vld || !i_res_stall;
    assign step         = r_in_vld && ((r_in_byte != '0) || out_free);
    assign o_text_stall = r_in_vld && !step;
    assign in_take      = i_text_valid && !o_text_stall;

    btr_scan u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_byte   (r_in_byte),
        .o_result (result)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take || step) begin
            r_in_vld <= in_take;
        end
        if (in_take) begin
            r_in_byte <= i_text_byte;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (result.done) begin
            r_out_vld <= 1'b1;
        end else if (!i_res_stall) begin
            r_out_vld <= 1'b0;
        end
        if (result.done) begin
            r_out_bool <= result.bool_value;
            r_out_ok   <= result.parse_ok;
        end
    end

    assign o_res_valid  = r_out_vld;
    assign o_bool_value = r_out_bool;
    assign o_parse_ok   = r_out_ok;

    // A byte that is held back stays in the input register.
    a_hold_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_text_stall |=> (r_in_vld && $stable(r_in_byte)))
        else $error("stalled input byte lost");

    // Only an end byte is ever held back.
    a_stall_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_text_stall |-> (r_in_byte == '0 && r_out_vld && i_res_stall))
        else $error("input stalled without a blocked result");

    // A new result never overwrites one the receiver has not taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        result.done |-> out_free)
        else $error("result register overwritten");

endmodule

FILE: tb/boolean_text_recognizer_checker.sv
module boolean_text_recognizer_checker
    import btr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_text_valid,
    input  logic             i_text_stall,
    input  logic [ByteW-1:0] i_text_byte,
    input  logic             i_res_valid,
    input  logic             i_res_stall,
    input  logic             i_bool_value,
    input  logic             i_parse_ok,
    output int               o_pending,
    output int               o_fail_count
);

    timeunit 1ns;
    timeprecision 1ps;

    // Where the scan of the current text stands.
    typedef enum logic [1:0] {
        SCAN_LEAD,
        SCAN_WORD,
        SCAN_TRAIL,
        SCAN_REJECT
    } t_scan;

    // One verdict per text, produced on its end byte.
    typedef struct packed {
        logic bool_value;
        logic parse_ok;
    } t_verdict;

    // Keyword spellings, lengths and the truth value of each slot.
    localparam logic [7:0] WORD_CHAR [8][5] = '{
        '{"t", "r", "u", "e", 8'h00},
        '{"f", "a", "l", "s", "e"},
        '{"y", "e", "s", 8'h00, 8'h00},
        '{"n", "o", 8'h00, 8'h00, 8'h00},
        '{"o", "n", 8'h00, 8'h00, 8'h00},
        '{"o", "f", "f", 8'h00, 8'h00},
        '{"1", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"0", 8'h00, 8'h00, 8'h00, 8'h00}
    };
    localparam int WORD_LEN [8] = '{4, 5, 3, 2, 2, 3, 1, 1};
    localparam logic [7:0] WORD_IS_TRUE = 8'b0101_0101;

    t_scan      scan_state;
    logic [7:0] live_words;
    logic [2:0] word_len;
    t_verdict   expected_verdicts[$];
    int         errors;

    assign o_fail_count = errors;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    // Keep the keywords whose next letter matches, and count the letter.
    task automatic match_letter(input logic [7:0] c);
        logic [7:0] keep;
        keep = '0;
        for (int k = 0; k < 8; k++) begin
            if (live_words[k] && word_len < WORD_LEN[k]) begin
                if (WORD_CHAR[k][word_len] == c) begin
                    keep[k] = 1'b1;
                end
            end
        end
        live_words = keep;
        if (word_len != 3'd7) begin
            word_len = word_len + 3'd1;
        end
    endtask

    // A surviving keyword counts only if the token length suits it.
    function automatic logic word_fits(input int k);
        if (!live_words[k] || word_len == 0 || word_len > WORD_LEN[k]) begin
            return 1'b0;
        end
        if (k == KW_ON) begin
            return word_len == 3'd2;
        end
        if (k == KW_OFF) begin
            return word_len >= 3'd2;
        end
        if (k == KW_ONE || k == KW_ZERO) begin
            return word_len == 3'd1;
        end
        return 1'b1;
    endfunction

    task automatic clear_scan();
        scan_state = SCAN_LEAD;
        live_words = '1;
        word_len   = '0;
    endtask

    // Advance the scan by one byte; the end byte yields the verdict.
    task automatic scan_text_byte(input logic [7:0] c);
        t_verdict v;
        v = '0;
        if (c != 8'h00) begin
            case (scan_state)
                SCAN_LEAD: begin
                    if (!is_space(c)) begin
                        scan_state = SCAN_WORD;
                        match_letter(to_lower(c));
                    end
                end
                SCAN_WORD: begin
                    if (is_space(c)) begin
                        scan_state = SCAN_TRAIL;
                    end else begin
                        match_letter(to_lower(c));
                    end
                end
                SCAN_TRAIL: begin
                    if (!is_space(c)) begin
                        scan_state = SCAN_REJECT;
                    end
                end
                default: begin
                end
            endcase
        end else begin
            if (scan_state == SCAN_WORD || scan_state == SCAN_TRAIL) begin
                for (int k = 0; k < 8; k++) begin
                    if (!v.parse_ok && word_fits(k)) begin
                        v.parse_ok   = 1'b1;
                        v.bool_value = WORD_IS_TRUE[k];
                    end
                end
            end
            expected_verdicts.push_back(v);
            clear_scan();
        end
    endtask

    initial begin
        errors = 0;
        clear_scan();
    end

    // Watch both channels at each edge; compare results, then predict.
    always @(posedge i_clk) begin
        t_verdict want;
        if (!i_rst_n) begin
            clear_scan();
            expected_verdicts.delete();
        end else begin
            if (i_res_valid && !i_res_stall) begin
                if (expected_verdicts.size() == 0) begin
                    $error("result request with no text pending: bool_value %0b parse_ok %0b",
                           i_bool_value, i_parse_ok);
                    errors++;
                end else begin
                    want = expected_verdicts.pop_front();
                    if (i_bool_value !== want.bool_value) begin
                        $error("bool_value: expected %0b, actual %0b",
                               want.bool_value, i_bool_value);
                        errors++;
                    end
                    if (i_parse_ok !== want.parse_ok) begin
                        $error("parse_ok: expected %0b, actual %0b",
                               want.parse_ok, i_parse_ok);
                        errors++;
                    end
                end
            end
            if (i_text_valid && !i_text_stall) begin
                scan_text_byte(i_text_byte);
            end
        end
        o_pending <= expected_verdicts.size();
    end

endmodule

FILE: tb/tb_boolean_text_recognizer_unit.sv
module tb_boolean_text_recognizer_unit;

    import btr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_BYTES = 1800;
    localparam int LONG_HOLD    = 150;

    logic             clk        = 1'b0;
    logic             rst_n      = 1'b0;
    logic             text_valid = 1'b0;
    logic [ByteW-1:0] text_byte  = '0;
    logic             res_stall  = 1'b0;
    logic             text_stall;
    logic             res_valid;
    logic             bool_value;
    logic             parse_ok;
    int               pending;
    int               fail_count;

    logic             long_hold_go = 1'b0;
    logic             steady_send  = 1'b0;
    int               burst_left   = 0;
    int               sent_bytes   = 0;
    logic [7:0]       text_buf[$];
    string            words[8] = '{"true", "false", "yes", "no", "on", "off", "1", "0"};

    always #5 clk = ~clk;

    boolean_text_recognizer_unit dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_text_valid (text_valid),
        .o_text_stall (text_stall),
        .i_text_byte  (text_byte),
        .o_res_valid  (res_valid),
        .i_res_stall  (res_stall),
        .o_bool_value (bool_value),
        .o_parse_ok   (parse_ok)
    );

    boolean_text_recognizer_checker u_verdict_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_text_valid (text_valid),
        .i_text_stall (text_stall),
        .i_text_byte  (text_byte),
        .i_res_valid  (res_valid),
        .i_res_stall  (res_stall),
        .i_bool_value (bool_value),
        .i_parse_ok   (parse_ok),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // Offer one byte, sometimes idling first when a burst has run out.
    task automatic push_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0 || steady_send) ? 0 : $urandom_range(1, 6);
            repeat (gap) begin
                text_valid <= 1'b0;
                text_byte  <= 8'($urandom);
                @(posedge clk);
            end
        end
        burst_left--;
        text_valid <= 1'b1;
        text_byte  <= b;
        @(posedge clk);
        while (text_stall) @(posedge clk);
        sent_bytes++;
    endtask

    // Send the buffered text followed by its end byte.
    task automatic send_text();
        foreach (text_buf[i]) push_byte(text_buf[i]);
        push_byte(8'h00);
        text_buf.delete();
    endtask

    task automatic send_string(input string s);
        for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
        send_text();
    endtask

    // Stop offering and wait until every text has its result.
    task automatic drain_results();
        text_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic add_blanks(input int n);
        int b;
        repeat (n) begin
            b = $urandom_range(8, 13);
            text_buf.push_back(b == 8 ? 8'h20 : 8'(b));
        end
    endtask

    // Letters of a keyword, each in random case.
    task automatic add_word(input int w, input int n);
        logic [7:0] c;
        for (int i = 0; i < n; i++) begin
            c = words[w][i % words[w].len()];
            if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1) c = c - 8'd32;
            text_buf.push_back(c);
        end
    endtask

    // Mostly keywords with random case and blanks, plus broken, blank-only and noise texts.
    task automatic build_random_text();
        int kind, w, n, len, pos;
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
            add_blanks($urandom_range(0, 2));
            w   = $urandom_range(0, 7);
            len = words[w].len();
            if (w == KW_ON) n = 2;
            else if (w == KW_OFF) n = $urandom_range(2, 3);
            else n = $urandom_range(1, len);
            if ($urandom_range(0, 9) == 0) n = $urandom_range(1, len + 2);
            add_word(w, n);
            if ($urandom_range(0, 9) == 0) begin
                pos = $urandom_range(0, text_buf.size() - 1);
                text_buf[pos] = 8'($urandom_range(1, 255));
            end
            add_blanks($urandom_range(0, 2));
            if ($urandom_range(0, 9) == 0) text_buf.push_back(8'($urandom_range(1, 255)));
        end else if (kind < 82) begin
            add_word($urandom_range(0, 7), $urandom_range(5, 10));
        end else if (kind < 88) begin
            add_blanks($urandom_range(0, 3));
        end else begin
            repeat ($urandom_range(1, 8)) text_buf.push_back(8'($urandom_range(1, 255)));
        end
    endtask

    // Receiver: free runs, solid stalls and random stalls, plus one long hold.
    initial begin
        logic hold_done;
        int   kind, run;
        hold_done = 1'b0;
        forever begin
            if (long_hold_go && !hold_done) begin
                for (int n = 0; n < LONG_HOLD; n++) begin
                    res_stall <= 1'b1;
                    @(posedge clk);
                end
                hold_done = 1'b1;
            end
            kind = $urandom_range(0, 3);
            run  = (kind == 0) ? $urandom_range(1, 40) : $urandom_range(1, 12);
            repeat (run) begin
                if (kind == 0) res_stall <= 1'b0;
                else if (kind == 1) res_stall <= 1'b1;
                else res_stall <= 1'($urandom_range(0, 1));
                @(posedge clk);
            end
        end
    end

    // Stimulus and verdict.
    initial begin
        int start_bytes;
        logic paused;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed texts: every keyword, edge cases and odd bytes.
        send_string("");
        send_string(" \t\n\v\f");
        send_string("T");
        send_string("FaLsE");
        send_string("\015yes\015");
        send_string("n");
        send_string("On");
        send_string("of");
        send_string("\tOFF ");
        send_string("1");
        send_string("0");
        send_string("o");
        send_string("no x");
        send_string("truee");
        send_string("offf");
        send_string("10");
        send_string("falsefalse");
        send_string("\200");
        send_string("y\377");
        drain_results();

        // Random texts with one long receiver hold and a drained pause midway.
        start_bytes  = sent_bytes;
        paused       = 1'b0;
        long_hold_go <= 1'b1;
        while (sent_bytes - start_bytes < RANDOM_BYTES) begin
            steady_send = (sent_bytes - start_bytes >= 300 && sent_bytes - start_bytes < 600);
            build_random_text();
            send_text();
            if (!paused && sent_bytes - start_bytes >= RANDOM_BYTES / 2) begin
                drain_results();
                paused = 1'b1;
            end
        end

        drain_results();
        repeat (10) @(posedge clk);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #3_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: filelist.f
src/btr_pkg.sv
src/btr_scan.sv
src/boolean_text_recognizer_unit.sv
tb/boolean_text_recognizer_checker.sv
tb/tb_boolean_text_recognizer_unit.sv
